@@ src/mp3s2_pkg.sv @@
// ----------------------------------------------------------------------------
// mp3s2_pkg
// Shared constants and float helpers for the 3x3 stride-2 max pooling block.
// ----------------------------------------------------------------------------
package mp3s2_pkg;

  localparam logic [31:0] LowestFloat = 32'hFF7F_FFFF;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegImageHeight  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegImageWidth   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPadRowsTotal = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPadColsTotal = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPooledHeight = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPooledWidth  = 3'd5;

  typedef logic [31:0] f32_t;

  // IEEE-754 a < b; false when either side is NaN, and +0 equals -0.
  function automatic logic f32_lt(input f32_t a, input f32_t b);
    logic a_nan, b_nan, both_zero, res;
    a_nan     = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan     = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (a[31] != b[31]) begin
      res = a[31];
    end else if (!a[31]) begin
      res = a[30:0] < b[30:0];
    end else begin
      res = a[30:0] > b[30:0];
    end
    return res && !a_nan && !b_nan && !both_zero;
  endfunction

  function automatic f32_t keep_max(input f32_t acc, input f32_t x);
    return f32_lt(acc, x) ? x : acc;
  endfunction

endpackage

@@ src/mp3s2_ram.sv @@
// ----------------------------------------------------------------------------
// mp3s2_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mp3s2_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/max_pool_3x3_stride2.sv @@
// Pipeline: a window's last item is registered in stage 1, its result then in the output
// register. Throughput: one item per cycle unless the output stalls, set by one read of
// each line buffer, at most one write per item, and write-to-read forwarding between items.
// Reset: asynchronous, active low; clears counters, running maximum, pipeline valids and
// configuration to its defaults. Line buffers are not cleared.
// ----------------------------------------------------------------------------
// max_pool_3x3_stride2
// Streaming 3x3 stride-2 max pooling over raster-order float pixels.
// ----------------------------------------------------------------------------
module max_pool_3x3_stride2 #(
  parameter int MAX_IMAGE_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [31:0]                   s_axis_tdata_i,  // [31:0] pixel
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [31:0]                   m_axis_tdata_o,  // [31:0] pooled
  output logic                          m_axis_tlast_o,  // plane_end
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mp3s2_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mp3s2_pkg::CfgDataW-1:0] cfg_data_i
);
  import mp3s2_pkg::*;

  localparam int WinDepth = (MAX_IMAGE_WIDTH + 1) / 2;
  localparam int AddrW    = $clog2(WinDepth);

  // Configuration
  logic [12:0] img_h_q;
  logic [10:0] img_w_q;
  logic [1:0]  pad_r_q, pad_c_q;
  logic [11:0] pool_h_q;
  logic [9:0]  pool_w_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_h_q  <= 13'd1;
      img_w_q  <= 11'd1;
      pad_r_q  <= 2'd0;
      pad_c_q  <= 2'd0;
      pool_h_q <= 12'd1;
      pool_w_q <= 10'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegImageHeight:  img_h_q  <= cfg_data_i[12:0];
        RegImageWidth:   img_w_q  <= cfg_data_i[10:0];
        RegPadRowsTotal: pad_r_q  <= cfg_data_i[1:0];
        RegPadColsTotal: pad_c_q  <= cfg_data_i[1:0];
        RegPooledHeight: pool_h_q <= cfg_data_i[11:0];
        RegPooledWidth:  pool_w_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Input side: position counters and horizontal running maximum
  logic [10:0] col_q, col_d;
  logic [12:0] row_q, row_d;
  f32_t        rmax_q, rmax_d;
  logic        accept;

  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic        c_last, r_last, col_close, row_close, in_range, emit, p_end;
  logic [11:0] u, wh;
  logic [13:0] v, hr;
  f32_t        hv;

  always_comb begin
    w_eff     = (img_w_q == 11'd0) ? 11'd1 : img_w_q;
    h_eff     = (img_h_q == 13'd0) ? 13'd1 : img_h_q;
    c_last    = (col_q == w_eff - 11'd1);
    r_last    = (row_q == h_eff - 13'd1);
    u         = {1'b0, col_q} + {11'd0, pad_c_q[1]};
    v         = {1'b0, row_q} + {13'd0, pad_r_q[1]};
    col_close = c_last || ((u >= 12'd2) && !u[0]);
    row_close = r_last || ((v >= 14'd2) && !v[0]);
    if (c_last) begin
      wh = (u >= 12'd1) ? ((u - 12'd1) >> 1) : 12'd0;
    end else begin
      wh = (u - 12'd2) >> 1;
    end
    if (r_last) begin
      hr = (v >= 14'd1) ? ((v - 14'd1) >> 1) : 14'd0;
    end else begin
      hr = (v - 14'd2) >> 1;
    end
    in_range = (32'(wh) < WinDepth);
    emit     = col_close && in_range && row_close &&
               (hr < {2'b00, pool_h_q}) && (wh < {2'b00, pool_w_q});
    p_end    = (hr == {2'b00, pool_h_q} - 14'd1) && (wh == {2'b00, pool_w_q} - 12'd1);
    hv       = keep_max((col_q == 11'd0) ? LowestFloat : rmax_q, s_axis_tdata_i);
    rmax_d   = !u[0] ? keep_max(LowestFloat, s_axis_tdata_i) : hv;
    col_d    = col_q + 11'd1;
    row_d    = row_q;
    if ({1'b0, col_q} + 12'd1 >= {1'b0, w_eff}) begin
      col_d = 11'd0;
      row_d = row_q + 13'd1;
      if ({1'b0, row_q} + 14'd1 >= {1'b0, h_eff}) begin
        row_d = 13'd0;
      end
    end
  end

  // Stage 1 holds the item while the line buffers are read
  logic             s1_valid_q, s1_emit_q, s1_end_q, s1_store_q, s1_veven_q, s1_rge1_q;
  f32_t             s1_hv_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             fwd_wpm_q, fwd_srm_q;
  f32_t             fwd_wpm_data_q, fwd_srm_data_q;
  logic             s1_adv, wpm_we, srm_we;
  f32_t             wpm_rd, srm_rd, wpm_cur, srm_cur, wpm_wdata, acc, res;
  logic [AddrW-1:0] rd_addr;
  logic             out_valid_q;
  f32_t             out_data_q;
  logic             out_last_q;

  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_addr         = wh[AddrW-1:0];

  always_comb begin
    wpm_cur   = fwd_wpm_q ? fwd_wpm_data_q : wpm_rd;
    srm_cur   = fwd_srm_q ? fwd_srm_data_q : srm_rd;
    wpm_wdata = s1_rge1_q ? keep_max(srm_cur, s1_hv_q) : s1_hv_q;
    acc       = s1_rge1_q ? (s1_veven_q ? wpm_cur : srm_cur) : LowestFloat;
    res       = keep_max(acc, s1_hv_q);
    wpm_we    = s1_adv && s1_store_q && !s1_veven_q;
    srm_we    = s1_adv && s1_store_q && s1_veven_q;
  end

  mp3s2_ram #(.Width(32), .Depth(WinDepth)) u_wpm_ram (
    .clk_i   (clk_i),
    .we_i    (wpm_we),
    .waddr_i (s1_addr_q),
    .wdata_i (wpm_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (wpm_rd)
  );

  mp3s2_ram #(.Width(32), .Depth(WinDepth)) u_srm_ram (
    .clk_i   (clk_i),
    .we_i    (srm_we),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_hv_q),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (srm_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= 11'd0;
      row_q       <= 13'd0;
      rmax_q      <= LowestFloat;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q  <= col_d;
        row_q  <= row_d;
        rmax_q <= rmax_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && s1_emit_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_hv_q    <= hv;
      s1_addr_q  <= rd_addr;
      s1_emit_q  <= emit;
      s1_end_q   <= p_end;
      s1_store_q <= col_close && in_range;
      s1_veven_q <= !v[0];
      s1_rge1_q  <= (row_q != 13'd0);
      // The RAM returns old data when the leaving item writes the same entry.
      fwd_wpm_q      <= wpm_we && (s1_addr_q == rd_addr);
      fwd_srm_q      <= srm_we && (s1_addr_q == rd_addr);
      fwd_wpm_data_q <= wpm_wdata;
      fwd_srm_data_q <= s1_hv_q;
    end
    if (s1_adv && s1_emit_q) begin
      out_data_q <= res;
      out_last_q <= s1_end_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ src/mp3s2_checker.sv @@
// ----------------------------------------------------------------------------
// mp3s2_checker
// Port-level checks for the max pooling block.
// ----------------------------------------------------------------------------
module mp3s2_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  // No result may be pending straight after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid_o)
    else $error("result present after reset");

  // A fresh result traces back to an accepted input item, held in stage 1 and then output.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) && $past(rst_ni, 2) |->
      $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("result without a matching input item");

endmodule

bind max_pool_3x3_stride2 mp3s2_checker u_mp3s2_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
